[design/rfab_pkg.sv]
// ----------------------------------------------------------------------------
// rfab_pkg
// Shared types and constants for the rectangle fill and alpha blend core.
// ----------------------------------------------------------------------------
package rfab_pkg;

    localparam int unsigned CoordW  = 14;
    localparam int unsigned SizeW   = 13;
    localparam int unsigned ColorW  = 24;
    localparam int unsigned AlphaW  = 9;
    localparam int unsigned PosW    = 12;
    localparam int unsigned PixelW  = 32;
    localparam int unsigned ChanW   = 8;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned DataW   = 32;
    localparam int unsigned InDataW = 56;

    localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;

    typedef enum logic [2:0] {
        REG_RECT_LEFT     = 3'd0,
        REG_RECT_TOP      = 3'd1,
        REG_RECT_RIGHT    = 3'd2,
        REG_RECT_BOTTOM   = 3'd3,
        REG_BUFFER_WIDTH  = 3'd4,
        REG_BUFFER_HEIGHT = 3'd5,
        REG_FILL_COLOR    = 3'd6,
        REG_ALPHA_CODE    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] rect_left;
        logic signed [CoordW-1:0] rect_top;
        logic signed [CoordW-1:0] rect_right;
        logic signed [CoordW-1:0] rect_bottom;
        logic        [SizeW-1:0]  buffer_width;
        logic        [SizeW-1:0]  buffer_height;
        logic        [ColorW-1:0] fill_color;
        logic        [AlphaW-1:0] alpha_code;
    } t_cfg;

endpackage

[design/rfab_regs.sv]
// ----------------------------------------------------------------------------
// rfab_regs
// APB register file holding the rectangle, clip size, fill color and alpha.
// ----------------------------------------------------------------------------
module rfab_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfab_pkg::AddrW-1:0]  paddr,
    input  logic [rfab_pkg::DataW-1:0]  pwdata,
    output logic [rfab_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output rfab_pkg::t_cfg              o_cfg
);
    import rfab_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RECT_LEFT:     r_cfg.rect_left     <= pwdata[CoordW-1:0];
                REG_RECT_TOP:      r_cfg.rect_top      <= pwdata[CoordW-1:0];
                REG_RECT_RIGHT:    r_cfg.rect_right    <= pwdata[CoordW-1:0];
                REG_RECT_BOTTOM:   r_cfg.rect_bottom   <= pwdata[CoordW-1:0];
                REG_BUFFER_WIDTH:  r_cfg.buffer_width  <= pwdata[SizeW-1:0];
                REG_BUFFER_HEIGHT: r_cfg.buffer_height <= pwdata[SizeW-1:0];
                REG_FILL_COLOR:    r_cfg.fill_color    <= pwdata[ColorW-1:0];
                REG_ALPHA_CODE:    r_cfg.alpha_code    <= pwdata[AlphaW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_RECT_LEFT:     prdata = DataW'(unsigned'(r_cfg.rect_left));
            REG_RECT_TOP:      prdata = DataW'(unsigned'(r_cfg.rect_top));
            REG_RECT_RIGHT:    prdata = DataW'(unsigned'(r_cfg.rect_right));
            REG_RECT_BOTTOM:   prdata = DataW'(unsigned'(r_cfg.rect_bottom));
            REG_BUFFER_WIDTH:  prdata = DataW'(r_cfg.buffer_width);
            REG_BUFFER_HEIGHT: prdata = DataW'(r_cfg.buffer_height);
            REG_FILL_COLOR:    prdata = DataW'(r_cfg.fill_color);
            REG_ALPHA_CODE:    prdata = DataW'(r_cfg.alpha_code);
            default:           prdata = '0;
        endcase
    end

endmodule

[design/rect_fill_alpha_blend_core.sv]
// ----------------------------------------------------------------------------
// rect_fill_alpha_blend_core
// Rectangle fill compositor: clip test and per-channel alpha blend per pixel.
// ----------------------------------------------------------------------------
// One pixel per clock: each transfer is captured in an input register, the clip
// test and the three 8x8 channel blends run in one combinational step, and the
// result is loaded into the output register once the output side can accept it
// and is offered from there. Throughput is one pixel per cycle whenever
// the output side is ready; with the output stalled the core holds two pixels
// and then drops s_axis_tready until the output side takes one. Program the
// registers over APB only while no pixel is in flight.
module rect_fill_alpha_blend_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfab_pkg::AddrW-1:0]    paddr,
    input  logic [rfab_pkg::DataW-1:0]    pwdata,
    output logic [rfab_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    // pixel input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rfab_pkg::InDataW-1:0]  s_axis_tdata,  // pixel_col, pixel_row, dst_pixel
    // pixel output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rfab_pkg::PixelW-1:0]   m_axis_tdata,  // pixel_out
    output logic                          m_axis_tuser   // write_enable
);
    import rfab_pkg::*;

    t_cfg w_cfg;

    logic                r_in_valid;
    logic [PosW-1:0]     r_col;
    logic [PosW-1:0]     r_row;
    logic [PixelW-1:0]   r_dst;
    logic                r_out_valid;
    logic                r_we;
    logic [PixelW-1:0]   r_pix;

    logic                w_adv;
    logic signed [CoordW:0] w_col, w_row, w_x0, w_y0, w_x1, w_y1, w_bw, w_bh;
    logic signed [CoordW:0] w_left, w_top, w_right, w_bottom;
    logic                w_inside;
    logic [ChanW-1:0]    w_a, w_na;
    logic [2*ChanW-1:0]  w_sum [3];
    logic [PixelW-1:0]   n_pix;
    logic                n_we;

    rfab_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_col    = $signed({3'b000, r_col});
    assign w_row    = $signed({3'b000, r_row});
    assign w_left   = (CoordW+1)'(w_cfg.rect_left);
    assign w_top    = (CoordW+1)'(w_cfg.rect_top);
    assign w_right  = (CoordW+1)'(w_cfg.rect_right);
    assign w_bottom = (CoordW+1)'(w_cfg.rect_bottom);
    assign w_bw     = $signed({2'b00, w_cfg.buffer_width});
    assign w_bh     = $signed({2'b00, w_cfg.buffer_height});
    assign w_x0     = (w_left > 0) ? w_left : '0;
    assign w_y0     = (w_top > 0) ? w_top : '0;
    assign w_x1     = (w_right < w_bw) ? w_right : w_bw;
    assign w_y1     = (w_bottom < w_bh) ? w_bottom : w_bh;
    assign w_inside = (w_col >= w_x0) && (w_col < w_x1) && (w_row >= w_y0) && (w_row < w_y1);

    assign w_a  = ChanW'(w_cfg.alpha_code - AlphaW'(1));
    assign w_na = AlphaOpaque - w_a;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = (2*ChanW)'(w_cfg.fill_color[c*ChanW +: ChanW]) * (2*ChanW)'(w_a)
                     + (2*ChanW)'(r_dst[c*ChanW +: ChanW]) * (2*ChanW)'(w_na);
        end
        n_we  = w_inside && (w_cfg.alpha_code != '0);
        n_pix = r_dst;
        if (n_we) begin
            if (w_cfg.alpha_code[AlphaW-1]) begin
                n_pix = {AlphaOpaque, w_cfg.fill_color};
            end else begin
                n_pix = {AlphaOpaque, w_sum[2][2*ChanW-1:ChanW],
                         w_sum[1][2*ChanW-1:ChanW], w_sum[0][2*ChanW-1:ChanW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_col <= s_axis_tdata[PosW-1:0];
            r_row <= s_axis_tdata[2*PosW-1:PosW];
            r_dst <= s_axis_tdata[2*PosW +: PixelW];
        end
        if (w_adv && r_in_valid) begin
            r_we  <= n_we;
            r_pix <= n_pix;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_pix;
    assign m_axis_tuser  = r_we;

    a_we_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_we) |-> (r_pix[PixelW-1 -: ChanW] == AlphaOpaque))
        else $error("written pixel without opaque alpha");

    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("input transfer not captured");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("result register not loaded");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_dst)))
        else $error("stalled input register changed");

endmodule
